FILE: src/cia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Complex integer ALU package
// Operation codes and the types that travel between the pipeline stages.
// ----------------------------------------------------------------------------
package cia_pkg;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_DIV = 2'd3
	} func_t;

	localparam int ResWidth = 32;

	// Saturate a signed value of up to 70 bits to 32 bits.
	function automatic logic [ResWidth-1:0] sat32(input logic signed [69:0] v);
		logic [ResWidth-1:0] r;
		if (v > 70'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -70'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[ResWidth-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/cia_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Complex integer ALU division cell
// One restoring step of two unsigned divisions that share a divisor, with
// the transaction's side data carried along the chain.
// ----------------------------------------------------------------------------
module cia_div_cell import cia_pkg::*; #(
	parameter int NW = 34,
	parameter int SHIFT = 0
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           advance,
	input  wire           in_valid,
	input  wire  [NW-1:0] in_rem_re,
	input  wire  [NW-1:0] in_rem_im,
	input  wire  [NW-1:0] in_den,
	input  wire           in_div,
	input  wire  [ResWidth-1:0] in_pre_re,
	input  wire  [ResWidth-1:0] in_pre_im,
	input  wire           in_neg_re,
	input  wire           in_neg_im,
	input  wire           in_ok,
	output logic          out_valid,
	output logic [NW-1:0] out_rem_re,
	output logic [NW-1:0] out_rem_im,
	output logic [NW-1:0] out_den,
	output logic          out_div,
	output logic [ResWidth-1:0] out_pre_re,
	output logic [ResWidth-1:0] out_pre_im,
	output logic          out_neg_re,
	output logic          out_neg_im,
	output logic          out_ok
);

	logic [NW+SHIFT:0] dsh;
	logic              take_re, take_im;
	logic [NW-1:0]     nxt_re, nxt_im;

	// The remainder stays below 2^(SHIFT+1)*den on entry, so one compare
	// and subtract decides this quotient bit.
	always_comb begin
		dsh     = {{(SHIFT+1){1'b0}}, in_den} << SHIFT;
		take_re = {{(SHIFT+1){1'b0}}, in_rem_re} >= dsh;
		take_im = {{(SHIFT+1){1'b0}}, in_rem_im} >= dsh;
		nxt_re  = take_re ? in_rem_re - dsh[NW-1:0] : in_rem_re;
		nxt_im  = take_im ? in_rem_im - dsh[NW-1:0] : in_rem_im;
	end

	logic [ResWidth-1:0] q_re_q, q_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_rem_re <= nxt_re;
			out_rem_im <= nxt_im;
			q_re_q     <= {in_pre_re[ResWidth-2:0], take_re};
			q_im_q     <= {in_pre_im[ResWidth-2:0], take_im};
			out_den    <= in_den;
			out_div    <= in_div;
			out_neg_re <= in_neg_re;
			out_neg_im <= in_neg_im;
			out_ok     <= in_ok;
		end
	end

	// Quotient accumulates MSB first in the pre fields.
	assign out_pre_re = q_re_q;
	assign out_pre_im = q_im_q;

endmodule
`default_nettype wire

FILE: src/complex_integer_alu_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Complex integer ALU
// Add, subtract, multiply or divide two complex numbers with integer parts.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the pipeline is not halted,
// and each gives one result after an operand stage, a product stage, a sum
// stage, a chain of 2*PART_WIDTH+2 one-bit division cells that every
// operation passes through, and a saturation stage. A division by zero
// gives zero parts with ok low; other results saturate to 32 bits with ok
// high. The whole pipeline halts while a valid output is stalled.
module complex_integer_alu_top import cia_pkg::*; #(
	parameter int PART_WIDTH = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire  [1:0]           func,
	input  wire  [PART_WIDTH-1:0] a_re,
	input  wire  [PART_WIDTH-1:0] a_im,
	input  wire  [PART_WIDTH-1:0] b_re,
	input  wire  [PART_WIDTH-1:0] b_im,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [ResWidth-1:0]  res_re,
	output logic [ResWidth-1:0]  res_im,
	output logic                 ok
);

	localparam int PW = 2 * PART_WIDTH;   // product width
	localparam int NW = PW + 2;           // magnitude width of sums
	localparam int NCELL = NW;

	logic advance;
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	// Stage 1: register the operands.
	logic                         v_s1;
	func_t                        f_s1;
	logic signed [PART_WIDTH-1:0] a_s1, b_s1, c_s1, d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			f_s1 <= func_t'(func);
			a_s1 <= a_re;
			b_s1 <= a_im;
			c_s1 <= b_re;
			d_s1 <= b_im;
		end
	end

	// Stage 2: the products, and the sum or difference for add and subtract.
	logic                 v_s2;
	func_t                f_s2;
	logic signed [PW-1:0] ac_s2, bd_s2, ad_s2, bc_s2, cc_s2, dd_s2;
	logic signed [PART_WIDTH:0] sre_s2, sim_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			f_s2  <= f_s1;
			ac_s2 <= a_s1 * c_s1;
			bd_s2 <= b_s1 * d_s1;
			ad_s2 <= a_s1 * d_s1;
			bc_s2 <= b_s1 * c_s1;
			cc_s2 <= c_s1 * c_s1;
			dd_s2 <= d_s1 * d_s1;
			case (f_s1)
				FUNC_SUB: begin
					sre_s2 <= $signed({a_s1[PART_WIDTH-1], a_s1})
						- $signed({c_s1[PART_WIDTH-1], c_s1});
					sim_s2 <= $signed({b_s1[PART_WIDTH-1], b_s1})
						- $signed({d_s1[PART_WIDTH-1], d_s1});
				end
				default: begin
					sre_s2 <= $signed({a_s1[PART_WIDTH-1], a_s1})
						+ $signed({c_s1[PART_WIDTH-1], c_s1});
					sim_s2 <= $signed({b_s1[PART_WIDTH-1], b_s1})
						+ $signed({d_s1[PART_WIDTH-1], d_s1});
				end
			endcase
		end
	end

	// Stage 3: signed sums, split into sign and magnitude for the divider.
	logic signed [NW:0] tre, tim;
	logic [NW:0]        den;
	logic               dz;

	always_comb begin
		den = (NW+1)'(unsigned'(cc_s2)) + (NW+1)'(unsigned'(dd_s2));
		dz  = (den == '0);
		case (f_s2)
			FUNC_MUL: begin
				tre = (NW+1)'(ac_s2) - (NW+1)'(bd_s2);
				tim = (NW+1)'(ad_s2) + (NW+1)'(bc_s2);
			end
			FUNC_DIV: begin
				tre = (NW+1)'(ac_s2) + (NW+1)'(bd_s2);
				tim = (NW+1)'(bc_s2) - (NW+1)'(ad_s2);
			end
			default: begin
				tre = (NW+1)'(sre_s2);
				tim = (NW+1)'(sim_s2);
			end
		endcase
	end

	logic [NW-1:0]       rem_re [NCELL+1];
	logic [NW-1:0]       rem_im [NCELL+1];
	logic [NW-1:0]       dv     [NCELL+1];
	logic                cv     [NCELL+1];
	logic                cdiv   [NCELL+1];
	logic [ResWidth-1:0] pre_re [NCELL+1];
	logic [ResWidth-1:0] pre_im [NCELL+1];
	logic                ng_re  [NCELL+1];
	logic                ng_im  [NCELL+1];
	logic                cok    [NCELL+1];
	logic                div_q;
	logic signed [NW:0]  tre_q, tim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv[0] <= 1'b0;
		end else if (advance) begin
			cv[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			div_q     <= (f_s2 == FUNC_DIV) && !dz;
			cok[0]    <= !((f_s2 == FUNC_DIV) && dz);
			tre_q     <= ((f_s2 == FUNC_DIV) && dz) ? '0 : tre;
			tim_q     <= ((f_s2 == FUNC_DIV) && dz) ? '0 : tim;
			dv[0]     <= dz ? NW'(1) : den[NW-1:0];
		end
	end

	// Non-division operations run with an all-ones divisor, which exceeds any
	// magnitude, so the cells take no bits and pass the value straight on.
	always_comb begin
		ng_re[0]  = tre_q[NW];
		ng_im[0]  = tim_q[NW];
		cdiv[0]   = div_q;
		rem_re[0] = tre_q[NW] ? NW'(-tre_q) : tre_q[NW-1:0];
		rem_im[0] = tim_q[NW] ? NW'(-tim_q) : tim_q[NW-1:0];
		pre_re[0] = '0;
		pre_im[0] = '0;
	end

	logic [NW-1:0] dv_eff;
	assign dv_eff = div_q ? dv[0] : '1;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		cia_div_cell #(
			.NW   (NW),
			.SHIFT(NCELL - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.in_valid  (cv[i]),
			.in_rem_re (rem_re[i]),
			.in_rem_im (rem_im[i]),
			.in_den    ((i == 0) ? dv_eff : dv[i]),
			.in_div    (cdiv[i]),
			.in_pre_re (pre_re[i]),
			.in_pre_im (pre_im[i]),
			.in_neg_re (ng_re[i]),
			.in_neg_im (ng_im[i]),
			.in_ok     (cok[i]),
			.out_valid (cv[i+1]),
			.out_rem_re(rem_re[i+1]),
			.out_rem_im(rem_im[i+1]),
			.out_den   (dv[i+1]),
			.out_div   (cdiv[i+1]),
			.out_pre_re(pre_re[i+1]),
			.out_pre_im(pre_im[i+1]),
			.out_neg_re(ng_re[i+1]),
			.out_neg_im(ng_im[i+1]),
			.out_ok    (cok[i+1])
		);
	end

	// Output stage: pick quotient or passed-through magnitude, restore the
	// sign and saturate.
	logic [NW-1:0]      mre, mim;
	logic signed [69:0] vre, vim;

	always_comb begin
		mre = cdiv[NCELL] ? NW'(pre_re[NCELL]) : rem_re[NCELL];
		mim = cdiv[NCELL] ? NW'(pre_im[NCELL]) : rem_im[NCELL];
		vre = ng_re[NCELL] ? -$signed(70'(mre)) : $signed(70'(mre));
		vim = ng_im[NCELL] ? -$signed(70'(mim)) : $signed(70'(mim));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= cv[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_re <= sat32(vre);
			res_im <= sat32(vim);
			ok     <= cok[NCELL];
		end
	end

`ifndef SYNTHESIS
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> res_re == '0 && res_im == '0)
		else $error("failed division carries nonzero parts");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_re) && $stable(ok))
		else $error("stalled result changed");
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/complex_integer_alu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex integer ALU checker
// Watches both channels, computes the expected complex result of every
// accepted transaction and compares it field by field with the results.
// ----------------------------------------------------------------------------
module complex_integer_alu_checker import cia_pkg::*; #(
	parameter int PART_WIDTH = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   in_stall,
	input  wire  [1:0]            func,
	input  wire  [PART_WIDTH-1:0] a_re,
	input  wire  [PART_WIDTH-1:0] a_im,
	input  wire  [PART_WIDTH-1:0] b_re,
	input  wire  [PART_WIDTH-1:0] b_im,
	input  wire                   out_valid,
	input  wire                   out_stall,
	input  wire  [31:0]           res_re,
	input  wire  [31:0]           res_im,
	input  wire                   ok,
	output int                    errors,
	output int                    pending,
	output int                    results_seen
);

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic        ok;
	} cplx_result_t;

	cplx_result_t expected_results[$];

	function automatic logic [31:0] clamp32(input logic signed [69:0] v);
		if (v > 70'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -70'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Exact arithmetic at 70 bits; SV division truncates toward zero.
	function automatic cplx_result_t complex_result(input func_t op,
			input logic signed [PART_WIDTH-1:0] ar, input logic signed [PART_WIDTH-1:0] ai,
			input logic signed [PART_WIDTH-1:0] br, input logic signed [PART_WIDTH-1:0] bi);
		logic signed [69:0] a, b, c, d, m, re, im;
		cplx_result_t r;
		a = ar; b = ai; c = br; d = bi;
		r.ok = 1'b1;
		case (op)
			FUNC_ADD: begin re = a + c; im = b + d; end
			FUNC_SUB: begin re = a - c; im = b - d; end
			FUNC_MUL: begin re = a * c - b * d; im = a * d + b * c; end
			default: begin
				m = c * c + d * d;
				if (m == 0) begin
					re = 0; im = 0; r.ok = 1'b0;
				end else begin
					re = (a * c + b * d) / m;
					im = (b * c - a * d) / m;
				end
			end
		endcase
		r.re = clamp32(re);
		r.im = clamp32(im);
		return r;
	endfunction

	initial begin
		errors = 0;
		results_seen = 0;
	end

	assign pending = expected_results.size();

	always @(posedge clk) begin
		cplx_result_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_results.push_back(complex_result(func_t'(func), a_re, a_im, b_re, b_im));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: unexpected result re=%h im=%h ok=%b", res_re, res_im, ok);
				end else begin
					e = expected_results.pop_front();
					if (e.re !== res_re || e.im !== res_im || e.ok !== ok) begin
						errors++;
						if (errors <= 10)
							$display("ERROR: expected re=%h im=%h ok=%b, got re=%h im=%h ok=%b",
								e.re, e.im, e.ok, res_re, res_im, ok);
					end
				end
			end
		end
	end

endmodule

FILE: tb/sv/complex_integer_alu_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex integer ALU testbench
// Drives directed corner operands and random operations through the block
// under varying idle patterns, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module complex_integer_alu_top_tb;
	import cia_pkg::*;

	localparam int PW = 16;
	localparam int LATENCY = 2 * PW + 6;
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic [1:0] func = '0;
	logic [PW-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	wire in_stall, out_valid, ok;
	wire [31:0] res_re, res_im;
	int errors, pending, results_seen;
	int send_idle_pct = 19, recv_idle_pct = 63;
	bit hold_off = 1'b0;
	int quiet_cycles = 0;
	int ops_sent = 0;

	always #5 clk = ~clk;

	complex_integer_alu_top #(.PART_WIDTH(PW)) dut (
		.clk, .arst_n, .in_valid, .in_stall, .func, .a_re, .a_im, .b_re, .b_im,
		.out_valid, .out_stall, .res_re, .res_im, .ok
	);

	complex_integer_alu_checker #(.PART_WIDTH(PW)) checker_inst (
		.clk, .arst_n, .in_valid, .in_stall, .func, .a_re, .a_im, .b_re, .b_im,
		.out_valid, .out_stall, .res_re, .res_im, .ok,
		.errors, .pending, .results_seen
	);

	// Receiver stall: random, or held high during a hold-off stretch.
	always @(posedge clk)
		out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("complex_integer_alu_top verification failed");
			$finish;
		end
	end

	// Picks operand values with a bias toward the extremes.
	function automatic logic [PW-1:0] pick_part();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return '0;
			3: return PW'($urandom_range(4) - 2);
			default: return PW'($urandom);
		endcase
	endfunction

	task automatic send_op(input func_t op, input logic [PW-1:0] ar, input logic [PW-1:0] ai,
			input logic [PW-1:0] br, input logic [PW-1:0] bi);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ops_sent++;
	endtask

	task automatic send_random(input int count);
		logic [PW-1:0] br, bi;
		for (int i = 0; i < count; i++) begin
			br = pick_part();
			bi = pick_part();
			// Divisions by zero are frequent enough from the picks above.
			send_op(func_t'($urandom_range(3)), pick_part(), pick_part(), br, bi);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operation at the extremes, zero divisor, small quotients.
		for (int op = 0; op < 4; op++) begin
			send_op(func_t'(op), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
			send_op(func_t'(op), 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
			send_op(func_t'(op), 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
			send_op(func_t'(op), 16'hFFFF, 16'h0001, 16'h0000, 16'h0000);
		end
		send_op(FUNC_DIV, 16'd7, 16'hFFF9, 16'd2, 16'd0);
		send_op(FUNC_DIV, 16'hFFF9, 16'd3, 16'd0, 16'hFFFE);
		send_op(FUNC_DIV, 16'd1, 16'd1, 16'h8000, 16'h8000);
		send_op(FUNC_MUL, 16'h8000, 16'h0000, 16'h8000, 16'h0000);
		send_op(FUNC_SUB, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		// Sender pauses until every expected result has come.
		drain();

		send_random(280);

		// Long receiver hold-off while the sender keeps offering items.
		hold_off = 1'b1;
		fork
			begin
				repeat (3 * LATENCY) @(posedge clk);
				hold_off = 1'b0;
			end
			send_random(60);
		join
		send_idle_pct = 63;
		recv_idle_pct = 19;
		send_random(250);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(240);
		drain();
		repeat (LATENCY + 4) @(posedge clk);

		$display("Ran %0d transactions over all four operations, with zero divisors,", ops_sent);
		$display("saturating extremes, idle patterns and a long output stall; %0d results.",
			results_seen);
		if (errors == 0 && pending == 0)
			$display("complex_integer_alu_top verification clean");
		else
			$display("complex_integer_alu_top verification failed");
		$finish;
	end

endmodule
